// ===== hdl/ywof_pkg.sv =====
// Shared types and constants of the yaw-rate offset window fit.
package ywof_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WINDOW = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WINDOW = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VALID_RATIO = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVING_THR = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTLIER_THR = 3'd4;

   localparam logic [1:0] WARM_IDLE = 2'd0;
   localparam logic [1:0] WARM_COUNT = 2'd1;
   localparam logic [1:0] WARM_DONE = 2'd2;

   localparam logic signed [21:0] MICRO = 22'sd1000000;

   typedef struct packed {
      logic [14:0] min_window;
      logic [14:0] max_window;
      logic [15:0] valid_ratio;
      logic [30:0] moving_threshold;
      logic [30:0] outlier_limit;
   } cfg_type;

   typedef struct packed {
      logic        usable;
      logic [31:0] heading;
      logic [31:0] rate;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic accept;
      logic p1_init;
      logic rd;
      logic p1_step;
      logic p2_init;
      logic sxy_add;
      logic p2_a;
      logic p2_b;
      logic mul_load;
      logic mul_step;
      logic mul_end;
      logic div_init;
      logic div_step;
      logic div_end;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic go_fit;
      logic last;
      logic ratio_ok;
      logic mul_done;
      logic mul_all;
      logic den_zero;
      logic div_done;
   } status_type;

endpackage

// ===== hdl/ywof_csr.sv =====
// Configuration registers of the yaw-rate offset window fit.
module ywof_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ywof_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ywof_pkg::CSR_DATA_W-1:0]    csr_data,
   output ywof_pkg::cfg_type                  cfg
);

   ywof_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ywof_pkg::CSR_MIN_WINDOW: cfg_in.min_window = csr_data[14:0];
            ywof_pkg::CSR_MAX_WINDOW: cfg_in.max_window = csr_data[14:0];
            ywof_pkg::CSR_VALID_RATIO: cfg_in.valid_ratio = csr_data[15:0];
            ywof_pkg::CSR_MOVING_THR: cfg_in.moving_threshold = csr_data;
            ywof_pkg::CSR_OUTLIER_THR: cfg_in.outlier_limit = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_window <= 15'd1500;
         cfg_ff.max_window <= 15'd15000;
         cfg_ff.valid_ratio <= 16'd3277;
         cfg_ff.moving_threshold <= 31'd182190;
         cfg_ff.outlier_limit <= 31'd33554;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/ywof_dp.sv =====
// Datapath: sample window memory, window walks, serial multiplier and divider.
module ywof_dp #(
   parameter int WINDOW_DEPTH = 16384
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ywof_pkg::cfg_type       cfg,
   input  ywof_pkg::cmd_type       cmd,
   output ywof_pkg::status_type    st,
   input  logic [159:0]            req_tdata,
   input  logic                    req_tuser,
   output logic [31:0]             rsp_tdata,
   output logic [1:0]              rsp_tuser
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int CW = $clog2(WINDOW_DEPTH + 1);

   ywof_pkg::entry_type mem [WINDOW_DEPTH];
   ywof_pkg::entry_type rd_ff;

   logic [AW-1:0]  head_ff, head_in, idx_ff, idx_in;
   logic [CW-1:0]  fill_ff, fill_in, k_ff, k_in, n_ff, n_in;
   logic [1:0]     phase_ff, phase_in;
   logic [14:0]    wcount_ff, wcount_in;
   logic           fit_en_ff, fit_en_in, done_ff, done_in, go_ff, go_in;
   logic [31:0]    last_ff, last_in, hl_ff, hl_in, stop_ff, stop_in;
   logic [31:0]    tprev_ff, tprev_in, tfirst_ff, tfirst_in, x_ff, x_in;
   logic           first_ff, first_in, u_ff, u_in;
   logic [63:0]    acc_ff, acc_in, total_ff, total_in, hprod_ff, hprod_in;
   logic [63:0]    sx_ff, sx_in, plo_ff, plo_in;
   logic [64:0]    phi_ff, phi_in;
   logic [127:0]   sxx_ff, sxx_in, sy_ff, sy_in, sxy_ff, sxy_in;
   logic [127:0]   ma_ff, ma_in, mp_ff, mp_in, tmp_ff, tmp_in;
   logic [127:0]   num_ff, num_in, den_ff, den_in;
   logic [63:0]    mb_ff, mb_in;
   logic [5:0]     mcnt_ff, mcnt_in;
   logic [1:0]     msel_ff, msel_in;
   logic [127:0]   dsh_ff, dsh_in, dd_ff, dd_in, rem_ff, rem_in, q_ff, q_in;
   logic           qneg_ff, qneg_in;
   logic [6:0]     dcnt_ff, dcnt_in;
   logic [31:0]    rdata_ff, rdata_in;
   logic [1:0]     ruser_ff, ruser_in;

   ywof_pkg::entry_type wr_ent;
   logic [14:0]    len_raw;
   logic [CW-1:0]  len;
   logic           usable;
   logic [CW:0]    base_sum;
   logic [AW-1:0]  base, idx_next;
   logic [31:0]    dt;
   logic signed [64:0] rprod;
   logic [63:0]    acc_add, y;
   logic signed [53:0] hp;
   logic [CW+15:0] ratio_l, ratio_r;
   logic [127:0]   neg_num, na;
   logic [128:0]   r2;
   logic [127:0]   qs;
   logic [31:0]    sat, lo;
   logic signed [32:0] dev;
   logic [32:0]    adev;

   always_comb begin
      len_raw = fit_en_ff ? cfg.max_window : cfg.min_window;
      if (len_raw == 15'd0) len = CW'(1);
      else if (32'(len_raw) > 32'(WINDOW_DEPTH)) len = CW'(WINDOW_DEPTH);
      else len = CW'(len_raw);
      usable = req_tuser &&
               ($signed(req_tdata[127:96]) > $signed({1'b0, cfg.moving_threshold}));
      wr_ent.usable = usable;
      wr_ent.heading = req_tdata[95:64];
      wr_ent.rate = req_tdata[63:32];
      wr_ent.stamp = req_tdata[31:0];
      base_sum = (CW+1)'(head_ff) + (CW+1)'(WINDOW_DEPTH) - (CW+1)'(fill_ff);
      base = (base_sum >= (CW+1)'(WINDOW_DEPTH)) ?
             AW'(base_sum - (CW+1)'(WINDOW_DEPTH)) : AW'(base_sum);
      idx_next = (idx_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : idx_ff + AW'(1);
      dt = rd_ff.stamp - tprev_ff;
      rprod = $signed({{33{rd_ff.rate[31]}}, rd_ff.rate}) * $signed({33'd0, dt});
      acc_add = first_ff ? acc_ff : acc_ff + rprod[63:0];
      hp = ($signed({rd_ff.heading[31], rd_ff.heading}) - $signed({hl_ff[31], hl_ff}))
           * ywof_pkg::MICRO;
      y = acc_ff - total_ff - hprod_ff;
      ratio_l = {n_ff, 16'd0};
      ratio_r = (CW+16)'(fill_ff) * (CW+16)'(cfg.valid_ratio);
      neg_num = -num_ff;
      na = neg_num[127] ? -neg_num : neg_num;
      r2 = {rem_ff, dsh_ff[127]};
      qs = qneg_ff ? -q_ff : q_ff;
      if (qs[127]) sat = (&qs[127:31]) ? qs[31:0] : 32'h8000_0000;
      else sat = (qs[127:31] == '0) ? qs[31:0] : 32'h7FFF_FFFF;
      lo = fit_en_ff ? last_ff : stop_ff;
      dev = $signed({lo[31], lo}) - $signed({stop_ff[31], stop_ff});
      adev = dev[32] ? 33'(-dev) : 33'(dev);
   end

   always_comb begin
      head_in = head_ff; fill_in = fill_ff; phase_in = phase_ff; wcount_in = wcount_ff;
      fit_en_in = fit_en_ff; done_in = done_ff; go_in = go_ff; last_in = last_ff;
      hl_in = hl_ff; stop_in = stop_ff; idx_in = idx_ff; k_in = k_ff; n_in = n_ff;
      tprev_in = tprev_ff; tfirst_in = tfirst_ff; x_in = x_ff; first_in = first_ff;
      u_in = u_ff; acc_in = acc_ff; total_in = total_ff; hprod_in = hprod_ff;
      sx_in = sx_ff; plo_in = plo_ff; phi_in = phi_ff; sxx_in = sxx_ff; sy_in = sy_ff;
      sxy_in = sxy_ff; ma_in = ma_ff; mb_in = mb_ff; mp_in = mp_ff; tmp_in = tmp_ff;
      num_in = num_ff; den_in = den_ff; mcnt_in = mcnt_ff; msel_in = msel_ff;
      dsh_in = dsh_ff; dd_in = dd_ff; rem_in = rem_ff; q_in = q_ff; qneg_in = qneg_ff;
      dcnt_in = dcnt_ff; rdata_in = rdata_ff; ruser_in = ruser_ff;

      if (cmd.accept) begin
         fill_in = (fill_ff < len) ? fill_ff + CW'(1) : len;
         head_in = (head_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : head_ff + AW'(1);
         unique case (phase_ff)
            ywof_pkg::WARM_IDLE: if (req_tuser) phase_in = ywof_pkg::WARM_COUNT;
            ywof_pkg::WARM_COUNT: begin
               if (wcount_ff < cfg.min_window) wcount_in = wcount_ff + 15'd1;
               else phase_in = ywof_pkg::WARM_DONE;
            end
            default: phase_in = phase_ff;
         endcase
         go_in = (phase_in == ywof_pkg::WARM_DONE) && usable;
         hl_in = req_tdata[95:64];
         stop_in = req_tdata[159:128];
         done_in = 1'b0;
      end
      if (cmd.p1_init || cmd.p2_init) begin
         idx_in = base; k_in = '0; first_in = 1'b1; acc_in = '0;
      end
      if (cmd.p1_init) n_in = '0;
      if (cmd.p1_step || cmd.p2_a) begin
         acc_in = acc_add;
         tprev_in = rd_ff.stamp;
         first_in = 1'b0;
      end
      if (cmd.p1_step) begin
         if (rd_ff.usable) begin
            if (n_ff == '0) tfirst_in = rd_ff.stamp;
            n_in = n_ff + CW'(1);
         end
      end
      if (cmd.p1_step || cmd.p2_b) begin
         idx_in = idx_next; k_in = k_ff + CW'(1);
      end
      if (cmd.p2_init) begin
         total_in = acc_ff; sx_in = '0; sxx_in = '0; sy_in = '0; sxy_in = '0;
         plo_in = '0; phi_in = '0; msel_in = '0;
      end
      if (cmd.sxy_add)
         sxy_in = sxy_ff + {64'd0, plo_ff} + {{31{phi_ff[64]}}, phi_ff, 32'd0};
      if (cmd.p2_a) begin
         hprod_in = 64'($signed(hp));
         x_in = rd_ff.stamp - tfirst_ff;
         u_in = rd_ff.usable;
      end
      if (cmd.p2_b) begin
         if (u_ff) begin
            sx_in = sx_ff + {32'd0, x_ff};
            sxx_in = sxx_ff + {64'd0, {32'd0, x_ff} * {32'd0, x_ff}};
            sy_in = sy_ff + {{64{y[63]}}, y};
            plo_in = {32'd0, x_ff} * {32'd0, y[31:0]};
            phi_in = $signed({1'b0, x_ff}) * $signed(y[63:32]);
         end else begin
            plo_in = '0; phi_in = '0;
         end
      end
      if (cmd.mul_load) begin
         mp_in = '0; mcnt_in = '0;
         unique case (msel_ff)
            2'd0: begin ma_in = sxy_ff; mb_in = 64'(n_ff); end
            2'd1: begin ma_in = sy_ff; mb_in = sx_ff; end
            2'd2: begin ma_in = sxx_ff; mb_in = 64'(n_ff); end
            default: begin ma_in = {64'd0, sx_ff}; mb_in = sx_ff; end
         endcase
      end
      if (cmd.mul_step) begin
         if (mb_ff[0]) mp_in = mp_ff + ma_ff;
         ma_in = {ma_ff[126:0], 1'b0};
         mb_in = {1'b0, mb_ff[63:1]};
         mcnt_in = mcnt_ff + 6'd1;
      end
      if (cmd.mul_end) begin
         unique case (msel_ff)
            2'd0, 2'd2: tmp_in = mp_ff;
            2'd1: num_in = tmp_ff - mp_ff;
            default: den_in = tmp_ff - mp_ff;
         endcase
         msel_in = msel_ff + 2'd1;
      end
      if (cmd.div_init) begin
         dsh_in = na;
         dd_in = den_ff[127] ? -den_ff : den_ff;
         qneg_in = neg_num[127] ^ den_ff[127];
         rem_in = '0; q_in = '0; dcnt_in = '0;
      end
      if (cmd.div_step) begin
         if (r2 >= {1'b0, dd_ff}) begin
            rem_in = 128'(r2 - {1'b0, dd_ff});
            q_in = {q_ff[126:0], 1'b1};
         end else begin
            rem_in = r2[127:0];
            q_in = {q_ff[126:0], 1'b0};
         end
         dsh_in = {dsh_ff[126:0], 1'b0};
         dcnt_in = dcnt_ff + 7'd1;
      end
      if (cmd.div_end) begin
         last_in = sat; fit_en_in = 1'b1; done_in = 1'b1;
      end
      if (cmd.out_load) begin
         last_in = (adev > {2'b00, cfg.outlier_limit}) ? stop_ff : lo;
         rdata_in = last_in;
         ruser_in = {done_ff, fit_en_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) mem[head_ff] <= wr_ent;
      if (cmd.rd) rd_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0; fill_ff <= '0; phase_ff <= ywof_pkg::WARM_IDLE;
         wcount_ff <= '0; fit_en_ff <= 1'b0; last_ff <= '0; done_ff <= 1'b0;
         go_ff <= 1'b0;
      end else begin
         head_ff <= head_in; fill_ff <= fill_in; phase_ff <= phase_in;
         wcount_ff <= wcount_in; fit_en_ff <= fit_en_in; last_ff <= last_in;
         done_ff <= done_in; go_ff <= go_in;
      end
   end

   always_ff @(posedge clock) begin
      hl_ff <= hl_in; stop_ff <= stop_in; idx_ff <= idx_in; k_ff <= k_in; n_ff <= n_in;
      tprev_ff <= tprev_in; tfirst_ff <= tfirst_in; x_ff <= x_in; first_ff <= first_in;
      u_ff <= u_in; acc_ff <= acc_in; total_ff <= total_in; hprod_ff <= hprod_in;
      sx_ff <= sx_in; plo_ff <= plo_in; phi_ff <= phi_in; sxx_ff <= sxx_in;
      sy_ff <= sy_in; sxy_ff <= sxy_in; ma_ff <= ma_in; mb_ff <= mb_in; mp_ff <= mp_in;
      tmp_ff <= tmp_in; num_ff <= num_in; den_ff <= den_in; mcnt_ff <= mcnt_in;
      msel_ff <= msel_in; dsh_ff <= dsh_in; dd_ff <= dd_in; rem_ff <= rem_in;
      q_ff <= q_in; qneg_ff <= qneg_in; dcnt_ff <= dcnt_in; rdata_ff <= rdata_in;
      ruser_ff <= ruser_in;
   end

   assign st.go_fit = go_ff;
   assign st.last = (k_ff == fill_ff - CW'(1));
   assign st.ratio_ok = ratio_l > ratio_r;
   assign st.mul_done = (mcnt_ff == 6'd63);
   assign st.mul_all = (msel_ff == 2'd3);
   assign st.den_zero = (den_ff == '0);
   assign st.div_done = (dcnt_ff == 7'd127);
   assign rsp_tdata = rdata_ff;
   assign rsp_tuser = ruser_ff;

endmodule

// ===== hdl/ywof_ctrl.sv =====
// Controller state machine sequencing window walks, products and division.
module ywof_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  ywof_pkg::status_type    st,
   output ywof_pkg::cmd_type       cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CHK = 4'd1;
   localparam logic [3:0] S_P1_RD = 4'd2;
   localparam logic [3:0] S_P1_EX = 4'd3;
   localparam logic [3:0] S_RATIO = 4'd4;
   localparam logic [3:0] S_P2_RD = 4'd5;
   localparam logic [3:0] S_P2_A = 4'd6;
   localparam logic [3:0] S_P2_B = 4'd7;
   localparam logic [3:0] S_P2_FIN = 4'd8;
   localparam logic [3:0] S_MUL_LD = 4'd9;
   localparam logic [3:0] S_MUL_RUN = 4'd10;
   localparam logic [3:0] S_MUL_END = 4'd11;
   localparam logic [3:0] S_DEN_CHK = 4'd12;
   localparam logic [3:0] S_DIV_RUN = 4'd13;
   localparam logic [3:0] S_DIV_END = 4'd14;
   localparam logic [3:0] S_OUT = 4'd15;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) begin
            cmd.accept = 1'b1; state_in = S_CHK;
         end
         S_CHK: begin
            if (st.go_fit) begin cmd.p1_init = 1'b1; state_in = S_P1_RD; end
            else state_in = S_OUT;
         end
         S_P1_RD: begin cmd.rd = 1'b1; state_in = S_P1_EX; end
         S_P1_EX: begin
            cmd.p1_step = 1'b1;
            state_in = st.last ? S_RATIO : S_P1_RD;
         end
         S_RATIO: begin
            if (st.ratio_ok) begin cmd.p2_init = 1'b1; state_in = S_P2_RD; end
            else state_in = S_OUT;
         end
         S_P2_RD: begin cmd.rd = 1'b1; cmd.sxy_add = 1'b1; state_in = S_P2_A; end
         S_P2_A: begin cmd.p2_a = 1'b1; state_in = S_P2_B; end
         S_P2_B: begin
            cmd.p2_b = 1'b1;
            state_in = st.last ? S_P2_FIN : S_P2_RD;
         end
         S_P2_FIN: begin cmd.sxy_add = 1'b1; state_in = S_MUL_LD; end
         S_MUL_LD: begin cmd.mul_load = 1'b1; state_in = S_MUL_RUN; end
         S_MUL_RUN: begin
            cmd.mul_step = 1'b1;
            if (st.mul_done) state_in = S_MUL_END;
         end
         S_MUL_END: begin
            cmd.mul_end = 1'b1;
            state_in = st.mul_all ? S_DEN_CHK : S_MUL_LD;
         end
         S_DEN_CHK: begin
            if (st.den_zero) state_in = S_OUT;
            else begin cmd.div_init = 1'b1; state_in = S_DIV_RUN; end
         end
         S_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (st.div_done) state_in = S_DIV_END;
         end
         S_DIV_END: begin cmd.div_end = 1'b1; state_in = S_OUT; end
         S_OUT: if (!rsp_valid_ff || rsp_tready) begin
            cmd.out_load = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_chk: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == S_CHK) else $error("accept did not start item");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready)) else $error("result overwritten");
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff) else $error("loaded result not presented");
   a_mul_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL_END |-> $past(st.mul_done)) else $error("product cut short");
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV_END |-> $past(st.div_done)) else $error("quotient cut short");

endmodule

// ===== hdl/yaw_rate_offset_window_fit_top.sv =====
// Sequence from accept to result: without a fit the result loads directly; when the usable ratio fails,
// it loads after the first window walk; a fit over F window samples runs two walks over the window,
// four shift-add products and a 128-step restoring division, which a zero divisor skips.
// One item at a time: the next item is taken at the earliest in the cycle after the result register loads,
// and loading waits while the previous result is still unread.
// Synchronous reset clears window, warm-up and fit state; window slots are read only once written.
module yaw_rate_offset_window_fit_top #(
   parameter int WINDOW_DEPTH = 16384
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // sample_time, rate, reference_heading, vehicle_speed, standstill_offset
   input  logic [159:0]                        req_tdata,
   // heading_valid
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // offset_out
   output logic [31:0]                         rsp_tdata,
   // offset_enabled, fit_done
   output logic [1:0]                          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ywof_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ywof_pkg::CSR_DATA_W-1:0]     csr_data
);

   ywof_pkg::cfg_type    cfg;
   ywof_pkg::cmd_type    cmd;
   ywof_pkg::status_type st;

   ywof_csr u_csr (
      .clock(clock), .reset(reset), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data), .cfg(cfg)
   );

   ywof_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .st(st), .cmd(cmd)
   );

   ywof_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cfg(cfg), .cmd(cmd), .st(st),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

endmodule
